/* src/rsd_pkg.sv */
// ----------------------------------------------------------------------------
// rsd_pkg: shared types for the running standard deviation accumulator
// Datapath command codes and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package rsd_pkg;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_DIV_AD,
    OP_MUL_AD_P,
    OP_DIV_PROD,
    OP_MEAN_Q,
    OP_MEAN_Q_SQ,
    OP_MUL_AD_DEV,
    OP_TERM_PROD,
    OP_MUL_SQ_C,
    OP_DIV_SQC,
    OP_MUL_Q1_P,
    OP_T1_MUL_R1P,
    OP_DIV_R1P,
    OP_ADD_Q2,
    OP_COMMIT,
    OP_DIV_M2,
    OP_SQRT,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic skip;
    logic early_ovf;
    logic zero;
    logic merge;
    logic adj_zero;
    logic div_done;
    logic mul_done;
    logic sqrt_done;
  } status_t;

endpackage

/* src/rsd_in_if.sv */
// ----------------------------------------------------------------------------
// rsd_in_if: input item channel
// Valid/ready channel carrying one sample or one partition merge request.
// ----------------------------------------------------------------------------
interface rsd_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] sample_value;
  logic               is_numeric;
  logic        [63:0] part_m2;
  logic signed [31:0] part_mean;
  logic        [31:0] part_count;

  modport source (
    output valid, req_type, sample_value, is_numeric, part_m2, part_mean, part_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, sample_value, is_numeric, part_m2, part_mean, part_count,
    output ready
  );
endinterface

/* src/rsd_out_if.sv */
// ----------------------------------------------------------------------------
// rsd_out_if: result item channel
// Valid/ready channel carrying the deviation and the partial state.
// ----------------------------------------------------------------------------
interface rsd_out_if;
  logic               valid;
  logic               ready;
  logic        [30:0] std_dev;
  logic               result_valid;
  logic        [63:0] cur_m2;
  logic signed [31:0] cur_mean;
  logic        [31:0] cur_count;
  logic               overflow;

  modport source (
    output valid, std_dev, result_valid, cur_m2, cur_mean, cur_count, overflow,
    input  ready
  );
  modport sink (
    input  valid, std_dev, result_valid, cur_m2, cur_mean, cur_count, overflow,
    output ready
  );
endinterface

/* src/running_std_dev_accumulator.sv */
// ----------------------------------------------------------------------------
// running_std_dev_accumulator: online variance with partition merge
// Keeps count, mean and m2 and returns the standard deviation per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item: a sample (req_type 0) or a partition partial
//   (req_type 1). out_ch returns one result item per input item: the standard
//   deviation, its valid flag, the updated m2, mean and count, and an
//   overflow flag for a dropped item. cfg_we/cfg_wdata select population (0)
//   or sample (1) deviation; write it only while the block is idle.
//   One item is worked on at a time. Its work is paced by the shared one-bit-
//   per-cycle divider and the 32-step square root; a skipped item whose
//   divisor count is zero bypasses both.
//   in_ch is ready again in the cycle after the result is registered, so the
//   next item enters while the result waits on a stalled receiver; a second
//   result is held until the first is taken.
//   Reset clears count, mean, m2 and the mode register.
// ----------------------------------------------------------------------------
module running_std_dev_accumulator #(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rsd_in_if.sink     in_ch,
  rsd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  rsd_pkg::op_t     op;
  rsd_pkg::status_t st;
  logic             in_ready;
  logic             out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  rsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .op        (op)
  );

  rsd_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_ch.req_type),
    .in_sample_value  (in_ch.sample_value),
    .in_is_numeric    (in_ch.is_numeric),
    .in_part_m2       (in_ch.part_m2),
    .in_part_mean     (in_ch.part_mean),
    .in_part_count    (in_ch.part_count),
    .out_std_dev      (out_ch.std_dev),
    .out_result_valid (out_ch.result_valid),
    .out_cur_m2       (out_ch.cur_m2),
    .out_cur_mean     (out_ch.cur_mean),
    .out_cur_count    (out_ch.cur_count),
    .out_overflow     (out_ch.overflow)
  );

endmodule

/* src/rsd_div.sv */
// ----------------------------------------------------------------------------
// rsd_div: restoring divider
// One quotient bit per cycle over a left-aligned dividend of nbits bits.
// ----------------------------------------------------------------------------
module rsd_div #(
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [127:0]     num,
  input  logic [7:0]       nbits,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [63:0]      quo,
  output logic [DEN_W-1:0] rem
);

  logic [127:0]     num_r;
  logic [7:0]       left_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [63:0]      quo_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_nxt;

  assign rem_sh  = {rem_r, num_r[127]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        left_r <= nbits;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r  <= {num_r[126:0], 1'b0};
        rem_r  <= rem_nxt[DEN_W-1:0];
        quo_r  <= {quo_r[62:0], ge};
        left_r <= left_r - 8'd1;
        if (left_r == 8'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* src/rsd_mul.sv */
// ----------------------------------------------------------------------------
// rsd_mul: sequential 64 by 64 multiplier
// Four 32 by 32 partial products, registered, then accumulated.
// ----------------------------------------------------------------------------
module rsd_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [2:0]   k_r;
  logic         pp_vld_r;
  logic         busy_r;
  logic         done_r;
  logic [31:0]  a_limb;
  logic [31:0]  b_limb;

  assign a_limb = k_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_limb = k_r[1] ? b_r[63:32] : b_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      pp_vld_r <= 1'b0;
      k_r      <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r      <= a;
        b_r      <= b;
        acc_r    <= '0;
        k_r      <= '0;
        pp_vld_r <= 1'b0;
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        if (k_r != 3'd4) begin
          pp_r     <= a_limb * b_limb;
          sh_r     <= {1'b0, k_r[0]} + {1'b0, k_r[1]};
          pp_vld_r <= 1'b1;
          k_r      <= k_r + 3'd1;
        end else begin
          pp_vld_r <= 1'b0;
        end
        if (pp_vld_r) begin
          acc_r <= acc_r + ({64'b0, pp_r} << {sh_r, 5'b0});
        end
        if (k_r == 3'd4 && pp_vld_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* src/rsd_sqrt.sv */
// ----------------------------------------------------------------------------
// rsd_sqrt: digit-by-digit integer square root
// One root bit per cycle over a 64-bit radicand.
// ----------------------------------------------------------------------------
module rsd_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  left_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_nxt;

  assign rem_sh  = {rem_r, rad_r[63:62]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_nxt = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
        left_r <= 6'd32;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= rem_nxt[33:0];
        root_r <= {root_r[30:0], ge};
        left_r <= left_r - 6'd1;
        if (left_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* src/rsd_datapath.sv */
// ----------------------------------------------------------------------------
// rsd_datapath: accumulator state, operand registers and arithmetic units
// Executes one controller command per cycle and reports status flags.
// ----------------------------------------------------------------------------
module rsd_datapath #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rsd_pkg::op_t       op,
  output rsd_pkg::status_t   st,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_req_type,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_is_numeric,
  input  logic        [63:0] in_part_m2,
  input  logic signed [31:0] in_part_mean,
  input  logic        [31:0] in_part_count,
  output logic        [30:0] out_std_dev,
  output logic               out_result_valid,
  output logic        [63:0] out_cur_m2,
  output logic signed [31:0] out_cur_mean,
  output logic        [31:0] out_cur_count,
  output logic               out_overflow
);

  localparam int CB = COUNT_BITS;
  localparam int SW = (CB > 32 ? CB : 32) + 1;

  logic          req_r;
  logic          numeric_r;
  logic [31:0]   val_r;
  logic [63:0]   pm2_r;
  logic [31:0]   pmean_r;
  logic [31:0]   p_r;
  logic [CB-1:0] cnt_r;
  logic [31:0]   mean_r;
  logic [63:0]   m2_r;
  logic          is_sample_r;
  logic [31:0]   ad_r;
  logic          neg_r;
  logic [CB-1:0] n_r;
  logic [31:0]   nm_r;
  logic [63:0]   term_r;
  logic [95:0]   t1_r;
  logic [CB-1:0] r1_r;
  logic          ovf_r;
  logic [30:0]   sd_o_r;
  logic          valid_o_r;
  logic [63:0]   m2_o_r;
  logic [31:0]   mean_o_r;
  logic [31:0]   cnt_o_r;
  logic          ovf_o_r;

  logic [32:0]   delta;
  logic [32:0]   delta_neg;
  logic [31:0]   ad_c;
  logic [SW-1:0] nsum;
  logic [CB-1:0] adj;
  logic [32:0]   mean_q;
  logic [32:0]   dev;
  logic [32:0]   dev_neg;
  logic [31:0]   dev_mag;
  logic [65:0]   total;
  logic [96:0]   q2sum;
  logic [30:0]   sd_sat;

  logic          div_start;
  logic [127:0]  div_num;
  logic [7:0]    div_nbits;
  logic [CB-1:0] div_den;
  logic          div_done;
  logic [63:0]   div_q;
  logic [CB-1:0] div_rem;
  logic          mul_start;
  logic [63:0]   mul_a;
  logic [63:0]   mul_b;
  logic          mul_done;
  logic [127:0]  mul_res;
  logic          sqrt_start;
  logic          sqrt_done;
  logic [31:0]   sqrt_root;

  assign delta     = req_r ? {pmean_r[31], pmean_r} - {mean_r[31], mean_r}
                           : {val_r[31], val_r} - {mean_r[31], mean_r};
  assign delta_neg = -delta;
  assign ad_c      = delta[32] ? delta_neg[31:0] : delta[31:0];
  assign nsum      = SW'(cnt_r) + SW'(p_r);
  assign adj       = (is_sample_r && cnt_r != '0) ? cnt_r - CB'(1) :
                     (is_sample_r ? '0 : cnt_r);
  assign mean_q    = neg_r ? {mean_r[31], mean_r} - {1'b0, div_q[31:0]}
                           : {mean_r[31], mean_r} + {1'b0, div_q[31:0]};
  assign dev       = {val_r[31], val_r} - {nm_r[31], nm_r};
  assign dev_neg   = -dev;
  assign dev_mag   = dev[32] ? dev_neg[31:0] : dev[31:0];
  assign total     = 66'(m2_r) + 66'(term_r) + (req_r ? 66'(pm2_r) : 66'd0);
  assign q2sum     = 97'(t1_r) + 97'(div_q[31:0]);
  assign sd_sat    = sqrt_root[31] ? {31{1'b1}} : sqrt_root[30:0];

  always_comb begin
    st.skip      = req_r ? (p_r == '0) : !numeric_r;
    st.early_ovf = req_r ? (nsum > SW'({CB{1'b1}})) : (&cnt_r);
    st.zero      = ad_c == '0;
    st.merge     = req_r;
    st.adj_zero  = adj == '0;
    st.div_done  = div_done;
    st.mul_done  = mul_done;
    st.sqrt_done = sqrt_done;
  end

  always_comb begin
    div_start  = 1'b0;
    div_num    = '0;
    div_nbits  = 8'd64;
    div_den    = n_r;
    mul_start  = 1'b0;
    mul_a      = 64'(ad_r);
    mul_b      = 64'(p_r);
    sqrt_start = 1'b0;
    case (op)
      rsd_pkg::OP_DIV_AD: begin
        div_start = 1'b1;
        div_num   = {ad_r, 96'b0};
        div_nbits = 8'd32;
      end
      rsd_pkg::OP_MUL_AD_P: begin
        mul_start = 1'b1;
      end
      rsd_pkg::OP_DIV_PROD: begin
        div_start = 1'b1;
        div_num   = {mul_res[63:0], 64'b0};
      end
      rsd_pkg::OP_MEAN_Q_SQ: begin
        mul_start = 1'b1;
        mul_b     = 64'(ad_r);
      end
      rsd_pkg::OP_MUL_AD_DEV: begin
        mul_start = 1'b1;
        mul_b     = 64'(dev_mag);
      end
      rsd_pkg::OP_MUL_SQ_C: begin
        mul_start = 1'b1;
        mul_a     = mul_res[63:0];
        mul_b     = 64'(cnt_r);
      end
      rsd_pkg::OP_DIV_SQC: begin
        div_start = 1'b1;
        div_num   = mul_res << (64 - CB);
        div_nbits = 8'(64 + CB);
      end
      rsd_pkg::OP_MUL_Q1_P: begin
        mul_start = 1'b1;
        mul_a     = div_q;
      end
      rsd_pkg::OP_T1_MUL_R1P: begin
        mul_start = 1'b1;
        mul_a     = 64'(r1_r);
      end
      rsd_pkg::OP_DIV_R1P: begin
        div_start = 1'b1;
        div_num   = mul_res << (96 - CB);
        div_nbits = 8'(CB + 32);
      end
      rsd_pkg::OP_DIV_M2: begin
        div_start = 1'b1;
        div_num   = {m2_r, 64'b0};
        div_den   = adj;
      end
      rsd_pkg::OP_SQRT: begin
        sqrt_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      mean_r      <= '0;
      m2_r        <= '0;
      is_sample_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        is_sample_r <= cfg_wdata;
      end
      case (op)
        rsd_pkg::OP_LOAD: begin
          req_r     <= in_req_type;
          numeric_r <= in_is_numeric;
          val_r     <= in_sample_value;
          pm2_r     <= in_part_m2;
          pmean_r   <= in_part_mean;
          p_r       <= in_part_count;
        end
        rsd_pkg::OP_SETUP: begin
          ad_r   <= ad_c;
          neg_r  <= delta[32];
          n_r    <= req_r ? nsum[CB-1:0] : cnt_r + CB'(1);
          nm_r   <= mean_r;
          term_r <= '0;
          ovf_r  <= !st.skip && st.early_ovf;
        end
        rsd_pkg::OP_MEAN_Q, rsd_pkg::OP_MEAN_Q_SQ: begin
          nm_r <= mean_q[31:0];
        end
        rsd_pkg::OP_TERM_PROD: begin
          term_r <= mul_res[63:0];
        end
        rsd_pkg::OP_MUL_Q1_P: begin
          r1_r <= div_rem;
        end
        rsd_pkg::OP_T1_MUL_R1P: begin
          t1_r <= mul_res[95:0];
        end
        rsd_pkg::OP_ADD_Q2: begin
          if (q2sum[96:64] != '0) begin
            ovf_r <= 1'b1;
          end else begin
            term_r <= q2sum[63:0];
          end
        end
        rsd_pkg::OP_COMMIT: begin
          if (!ovf_r) begin
            if (total[65:64] != 2'b00) begin
              ovf_r <= 1'b1;
            end else begin
              m2_r   <= total[63:0];
              mean_r <= nm_r;
              cnt_r  <= n_r;
            end
          end
        end
        rsd_pkg::OP_OUT: begin
          sd_o_r    <= st.adj_zero ? '0 : sd_sat;
          valid_o_r <= !st.adj_zero;
          m2_o_r    <= m2_r;
          mean_o_r  <= mean_r;
          cnt_o_r   <= 32'(cnt_r);
          ovf_o_r   <= ovf_r;
        end
        default: begin
        end
      endcase
    end
  end

  rsd_div #(.DEN_W(CB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .nbits (div_nbits),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_rem)
  );

  rsd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_res)
  );

  rsd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (div_q),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign out_std_dev      = sd_o_r;
  assign out_result_valid = valid_o_r;
  assign out_cur_m2       = m2_o_r;
  assign out_cur_mean     = mean_o_r;
  assign out_cur_count    = cnt_o_r;
  assign out_overflow     = ovf_o_r;

endmodule

/* src/rsd_ctrl.sv */
// ----------------------------------------------------------------------------
// rsd_ctrl: sequencer for the accumulator
// Steps the datapath through one sample or merge item and its result.
// ----------------------------------------------------------------------------
module rsd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rsd_pkg::status_t st,
  output rsd_pkg::op_t     op
);

  typedef enum logic [4:0] {
    IDLE, SETUP, GO, W_SDIV, S_DEV, W_SMUL, W_MAP, W_MDIV0, W_MAA, W_MSQC,
    W_MDIV1, W_MQ1P, W_MR1P, W_MDIV2, COMMIT, RESULT, W_RDIV, W_SQRT, OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    op        = rsd_pkg::OP_NONE;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          op        = rsd_pkg::OP_LOAD;
          state_nxt = SETUP;
        end
      end
      SETUP: begin
        op = rsd_pkg::OP_SETUP;
        if (st.skip || st.early_ovf) begin
          state_nxt = RESULT;
        end else if (st.zero) begin
          state_nxt = COMMIT;
        end else begin
          state_nxt = GO;
        end
      end
      GO: begin
        op        = st.merge ? rsd_pkg::OP_MUL_AD_P : rsd_pkg::OP_DIV_AD;
        state_nxt = st.merge ? W_MAP : W_SDIV;
      end
      W_SDIV: if (st.div_done) begin
        op        = rsd_pkg::OP_MEAN_Q;
        state_nxt = S_DEV;
      end
      S_DEV: begin
        op        = rsd_pkg::OP_MUL_AD_DEV;
        state_nxt = W_SMUL;
      end
      W_SMUL: if (st.mul_done) begin
        op        = rsd_pkg::OP_TERM_PROD;
        state_nxt = COMMIT;
      end
      W_MAP: if (st.mul_done) begin
        op        = rsd_pkg::OP_DIV_PROD;
        state_nxt = W_MDIV0;
      end
      W_MDIV0: if (st.div_done) begin
        op        = rsd_pkg::OP_MEAN_Q_SQ;
        state_nxt = W_MAA;
      end
      W_MAA: if (st.mul_done) begin
        op        = rsd_pkg::OP_MUL_SQ_C;
        state_nxt = W_MSQC;
      end
      W_MSQC: if (st.mul_done) begin
        op        = rsd_pkg::OP_DIV_SQC;
        state_nxt = W_MDIV1;
      end
      W_MDIV1: if (st.div_done) begin
        op        = rsd_pkg::OP_MUL_Q1_P;
        state_nxt = W_MQ1P;
      end
      W_MQ1P: if (st.mul_done) begin
        op        = rsd_pkg::OP_T1_MUL_R1P;
        state_nxt = W_MR1P;
      end
      W_MR1P: if (st.mul_done) begin
        op        = rsd_pkg::OP_DIV_R1P;
        state_nxt = W_MDIV2;
      end
      W_MDIV2: if (st.div_done) begin
        op        = rsd_pkg::OP_ADD_Q2;
        state_nxt = COMMIT;
      end
      COMMIT: begin
        op        = rsd_pkg::OP_COMMIT;
        state_nxt = RESULT;
      end
      RESULT: begin
        if (st.adj_zero) begin
          state_nxt = OUT;
        end else begin
          op        = rsd_pkg::OP_DIV_M2;
          state_nxt = W_RDIV;
        end
      end
      W_RDIV: if (st.div_done) begin
        op        = rsd_pkg::OP_SQRT;
        state_nxt = W_SQRT;
      end
      W_SQRT: if (st.sqrt_done) begin
        state_nxt = OUT;
      end
      OUT: if (out_free) begin
        op        = rsd_pkg::OP_OUT;
        state_nxt = IDLE;
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = state_r == IDLE;
  assign out_valid = out_valid_r;

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == SETUP)
    else $error("accepted item did not enter setup");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == W_SDIV || state_r == W_MDIV0 || state_r == W_MDIV1 ||
                     state_r == W_MDIV2 || state_r == W_RDIV))
    else $error("divider finished outside a divide wait");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    st.sqrt_done |-> state_r == W_SQRT)
    else $error("square root finished outside its wait");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == OUT && out_valid_r && !out_ready) |=> state_r == OUT)
    else $error("result overwritten while stalled");

endmodule
